// ----- rtl/rabd_pkg.sv -----
// ----------------------------------------------------------------------------
// rabd_pkg
// Shared types and codes of the array/bulk request deframer.
// ----------------------------------------------------------------------------
package rabd_pkg;

  localparam int MaxDepth  = 16;
  localparam int LenDigits = 9;
  localparam int LvlW      = $clog2(MaxDepth + 1);
  localparam int IdxW      = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;

  // byte classes found by the front end
  localparam logic [2:0] CLS_OTHER  = 3'd0;
  localparam logic [2:0] CLS_STAR   = 3'd1;
  localparam logic [2:0] CLS_DOLLAR = 3'd2;
  localparam logic [2:0] CLS_DIGIT  = 3'd3;
  localparam logic [2:0] CLS_DASH   = 3'd4;
  localparam logic [2:0] CLS_CR     = 3'd5;
  localparam logic [2:0] CLS_LF     = 3'd6;

  localparam logic [7:0] CHR_STAR   = 8'h2a;
  localparam logic [7:0] CHR_DOLLAR = 8'h24;
  localparam logic [7:0] CHR_DASH   = 8'h2d;
  localparam logic [7:0] CHR_CR     = 8'h0d;
  localparam logic [7:0] CHR_LF     = 8'h0a;
  localparam logic [7:0] CHR_ONE    = 8'h31;
  localparam logic [7:0] CHR_DIG_LO = 8'd47;
  localparam logic [7:0] CHR_DIG_HI = 8'd58;

  // byte roles
  localparam logic [2:0] ROLE_TYPE  = 3'd0;
  localparam logic [2:0] ROLE_LCHR  = 3'd1;
  localparam logic [2:0] ROLE_LTERM = 3'd2;
  localparam logic [2:0] ROLE_PAY   = 3'd3;
  localparam logic [2:0] ROLE_PTERM = 3'd4;
  localparam logic [2:0] ROLE_ERR   = 3'd5;

  // element kinds
  localparam logic [2:0] KIND_NONE      = 3'd0;
  localparam logic [2:0] KIND_ARR_OPEN  = 3'd1;
  localparam logic [2:0] KIND_BULK      = 3'd2;
  localparam logic [2:0] KIND_BULK_EMPTY = 3'd3;
  localparam logic [2:0] KIND_BULK_NIL  = 3'd4;
  localparam logic [2:0] KIND_ARR_EMPTY = 3'd5;
  localparam logic [2:0] KIND_ARR_NIL   = 3'd6;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_LEN_CHR  = 3'd1;
  localparam logic [2:0] ERR_LEN_LONG = 3'd2;
  localparam logic [2:0] ERR_TOO_BIG  = 3'd3;
  localparam logic [2:0] ERR_TERM     = 3'd4;
  localparam logic [2:0] ERR_TYPE     = 3'd5;
  localparam logic [2:0] ERR_DEEP     = 3'd6;

  localparam logic [29:0] MAX_BULK_RST = 30'h2000_0000;

  // classified byte passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] cls;
  } item_t;

endpackage

// ----- rtl/rabd_if.sv -----
// ----------------------------------------------------------------------------
// rabd_if
// Valid/ready channels: byte input and parse result output.
// ----------------------------------------------------------------------------
interface rabd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface rabd_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_role;
  logic [7:0]  byte_echo;
  logic [4:0]  nesting_depth;
  logic [2:0]  element_kind;
  logic [29:0] length_value;
  logic        payload_last;
  logic [4:0]  arrays_closed;
  logic        message_done;
  logic [2:0]  error_code;

  modport source (output valid, output byte_role, output byte_echo,
                  output nesting_depth, output element_kind, output length_value,
                  output payload_last, output arrays_closed, output message_done,
                  output error_code, input ready);
  modport sink   (input valid, input byte_role, input byte_echo,
                  input nesting_depth, input element_kind, input length_value,
                  input payload_last, input arrays_closed, input message_done,
                  input error_code, output ready);
endinterface

// ----- rtl/resp_array_bulk_deframer_core.sv -----
// ----------------------------------------------------------------------------
// resp_array_bulk_deframer_core
// Deframes array and bulk string request frames, one byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one stream byte per transfer (valid/ready).
//   out_ch : exactly one result per input byte, in order: byte role, echo,
//            nesting depth, completed element, arrays closed, message done
//            and error code.
//   cfg_wr_en/cfg_wr_data : writes the maximum bulk length; write only idle.
// Each byte is registered in the queue and then in the result register. A
// byte that completes an element is parked in the close registers while
// the stack walk pops one level per cycle, as long as the result register
// is free. Otherwise one byte per cycle is sustained while results are taken.
// A two-entry queue separates byte intake from the parser. The parser only
// takes a byte when no close cascade runs and the result register is empty
// or being taken, so outside cascades it keeps pace while results are taken.
// When the receiver stalls, the result holds, the queue fills and in_ch
// ready drops. Reset empties queue and stack, returns the parser to
// expecting a type byte and sets the maximum bulk length to 2^29.
// ----------------------------------------------------------------------------
module resp_array_bulk_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  rabd_byte_if.sink   in_ch,
  rabd_res_if.source  out_ch,
  input  logic        cfg_wr_en,
  input  logic [29:0] cfg_wr_data
);

  logic            q_valid;
  logic            q_pop;
  rabd_pkg::item_t q_item;

  // intake and classification
  rabd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // parser and result stage
  rabd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule

// ----- rtl/rabd_front.sv -----
// ----------------------------------------------------------------------------
// rabd_front
// Accepts bytes, classifies them and queues them in a two-entry FIFO.
// ----------------------------------------------------------------------------
module rabd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  rabd_byte_if.sink            in_ch,
  output logic                 q_valid,
  output rabd_pkg::item_t      q_item,
  input  logic                 q_pop
);

  rabd_pkg::item_t q_mem_r [2];
  logic            wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [2:0]      cls;
  logic            push;

  // byte classification
  always_comb begin
    if (in_ch.data_byte == rabd_pkg::CHR_STAR)
      cls = rabd_pkg::CLS_STAR;
    else if (in_ch.data_byte == rabd_pkg::CHR_DOLLAR)
      cls = rabd_pkg::CLS_DOLLAR;
    else if (in_ch.data_byte > rabd_pkg::CHR_DIG_LO && in_ch.data_byte < rabd_pkg::CHR_DIG_HI)
      cls = rabd_pkg::CLS_DIGIT;
    else if (in_ch.data_byte == rabd_pkg::CHR_DASH)
      cls = rabd_pkg::CLS_DASH;
    else if (in_ch.data_byte == rabd_pkg::CHR_CR)
      cls = rabd_pkg::CLS_CR;
    else if (in_ch.data_byte == rabd_pkg::CHR_LF)
      cls = rabd_pkg::CLS_LF;
    else
      cls = rabd_pkg::CLS_OTHER;
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_item      = q_mem_r[rp_r];

  // pointers and fill count
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= '{data: in_ch.data_byte, cls: cls};
    end
  end

endmodule

// ----- rtl/rabd_back.sv -----
// ----------------------------------------------------------------------------
// rabd_back
// Parser state machine, array count stack, close cascade and result register.
// ----------------------------------------------------------------------------
module rabd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic [29:0]     cfg_wr_data,
  input  logic            q_valid,
  input  rabd_pkg::item_t q_item,
  output logic            q_pop,
  rabd_res_if.source      out_ch
);

  localparam logic [3:0] PH_TYPE   = 4'd0;
  localparam logic [3:0] PH_LFIRST = 4'd1;
  localparam logic [3:0] PH_LDIG   = 4'd2;
  localparam logic [3:0] PH_NEG1   = 4'd3;
  localparam logic [3:0] PH_NEGCR  = 4'd4;
  localparam logic [3:0] PH_LLF    = 4'd5;
  localparam logic [3:0] PH_PAY    = 4'd6;
  localparam logic [3:0] PH_PCR    = 4'd7;
  localparam logic [3:0] PH_PLF    = 4'd8;

  localparam int LvlW = rabd_pkg::LvlW;
  localparam int IdxW = rabd_pkg::IdxW;

  logic [29:0]     max_bulk_r;
  logic [3:0]      ph_r, ph_nxt;
  logic [29:0]     acc_r, acc_nxt;
  logic [3:0]      dcnt_r, dcnt_nxt;
  logic            neg_r, neg_nxt, arr_r, arr_nxt;
  logic [29:0]     rem_r, rem_nxt;
  logic [LvlW-1:0] lvl_r, lvl_nxt;
  logic [29:0]     stk_r [rabd_pkg::MaxDepth];
  logic            closing_r, closing_nxt;

  // result held while the close cascade runs
  logic [2:0]      pk_role_r, pk_role_nxt, pk_kind_r, pk_kind_nxt;
  logic [29:0]     pk_len_r, pk_len_nxt;
  logic [7:0]      pk_byte_r, pk_byte_nxt;
  logic [4:0]      pk_closed_r, pk_closed_nxt;

  // output register
  logic            ov_r, ov_nxt;
  logic [2:0]      o_role_r, o_role_nxt, o_kind_r, o_kind_nxt, o_err_r, o_err_nxt;
  logic [7:0]      o_byte_r, o_byte_nxt;
  logic [4:0]      o_depth_r, o_depth_nxt, o_closed_r, o_closed_nxt;
  logic [29:0]     o_len_r, o_len_nxt;
  logic            o_last_r, o_last_nxt, o_done_r, o_done_nxt;

  logic            stk_we;
  logic [IdxW-1:0] stk_wa;
  logic [29:0]     stk_wd;

  logic            out_free;
  logic [2:0]      role, kind, err;
  logic [29:0]     len;
  logic            last, fin;
  logic [7:0]      b;
  logic [2:0]      cls;
  logic [IdxW-1:0] top_idx;
  logic [29:0]     top_dec;
  logic [29:0]     acc_x10;

  assign out_free = !ov_r || out_ch.ready;
  assign b        = q_item.data;
  assign cls      = q_item.cls;
  assign top_idx  = IdxW'(lvl_r - LvlW'(1));
  assign top_dec  = stk_r[top_idx] - 30'd1;
  assign acc_x10  = {acc_r[26:0], 3'b000} + {acc_r[28:0], 1'b0};

  always_comb begin
    ph_nxt        = ph_r;
    acc_nxt       = acc_r;
    dcnt_nxt      = dcnt_r;
    neg_nxt       = neg_r;
    arr_nxt       = arr_r;
    rem_nxt       = rem_r;
    lvl_nxt       = lvl_r;
    closing_nxt   = closing_r;
    pk_role_nxt   = pk_role_r;
    pk_kind_nxt   = pk_kind_r;
    pk_len_nxt    = pk_len_r;
    pk_byte_nxt   = pk_byte_r;
    pk_closed_nxt = pk_closed_r;
    ov_nxt        = ov_r && !out_ch.ready;
    o_role_nxt    = o_role_r;
    o_kind_nxt    = o_kind_r;
    o_err_nxt     = o_err_r;
    o_byte_nxt    = o_byte_r;
    o_depth_nxt   = o_depth_r;
    o_closed_nxt  = o_closed_r;
    o_len_nxt     = o_len_r;
    o_last_nxt    = o_last_r;
    o_done_nxt    = o_done_r;
    stk_we        = 1'b0;
    stk_wa        = top_idx;
    stk_wd        = top_dec;
    q_pop         = 1'b0;
    role          = rabd_pkg::ROLE_TYPE;
    kind          = rabd_pkg::KIND_NONE;
    err           = rabd_pkg::ERR_NONE;
    len           = '0;
    last          = 1'b0;
    fin           = 1'b0;

    if (closing_r) begin
      // one stack level per cycle while the result register is free
      if (out_free) begin
        if (lvl_r == '0) begin
          closing_nxt  = 1'b0;
          ov_nxt       = 1'b1;
          o_role_nxt   = pk_role_r;
          o_kind_nxt   = pk_kind_r;
          o_len_nxt    = pk_len_r;
          o_byte_nxt   = pk_byte_r;
          o_err_nxt    = rabd_pkg::ERR_NONE;
          o_last_nxt   = 1'b0;
          o_closed_nxt = pk_closed_r;
          o_done_nxt   = 1'b1;
          o_depth_nxt  = 5'(lvl_r);
        end else begin
          stk_we = 1'b1;
          if (top_dec != '0) begin
            closing_nxt  = 1'b0;
            ov_nxt       = 1'b1;
            o_role_nxt   = pk_role_r;
            o_kind_nxt   = pk_kind_r;
            o_len_nxt    = pk_len_r;
            o_byte_nxt   = pk_byte_r;
            o_err_nxt    = rabd_pkg::ERR_NONE;
            o_last_nxt   = 1'b0;
            o_closed_nxt = pk_closed_r;
            o_done_nxt   = 1'b0;
            o_depth_nxt  = 5'(lvl_r);
          end else begin
            lvl_nxt       = lvl_r - LvlW'(1);
            pk_closed_nxt = pk_closed_r + 5'd1;
          end
        end
      end
    end else if (q_valid && out_free) begin
      q_pop = 1'b1;
      unique case (ph_r)
        PH_TYPE: begin
          role = rabd_pkg::ROLE_TYPE;
          if (cls == rabd_pkg::CLS_STAR || cls == rabd_pkg::CLS_DOLLAR) begin
            arr_nxt  = (cls == rabd_pkg::CLS_STAR);
            acc_nxt  = '0;
            dcnt_nxt = '0;
            neg_nxt  = 1'b0;
            ph_nxt   = PH_LFIRST;
          end else begin
            err = rabd_pkg::ERR_TYPE;
          end
        end
        PH_LFIRST: begin
          role = rabd_pkg::ROLE_LCHR;
          if (cls == rabd_pkg::CLS_DIGIT) begin
            acc_nxt  = {26'd0, b[3:0]};
            dcnt_nxt = 4'd1;
            ph_nxt   = PH_LDIG;
          end else if (cls == rabd_pkg::CLS_DASH) begin
            neg_nxt = 1'b1;
            ph_nxt  = PH_NEG1;
          end else begin
            err = rabd_pkg::ERR_LEN_CHR;
          end
        end
        PH_LDIG: begin
          if (cls == rabd_pkg::CLS_DIGIT) begin
            role = rabd_pkg::ROLE_LCHR;
            if (dcnt_r >= 4'(rabd_pkg::LenDigits)) begin
              err = rabd_pkg::ERR_LEN_LONG;
            end else begin
              acc_nxt  = acc_x10 + {26'd0, b[3:0]};
              dcnt_nxt = dcnt_r + 4'd1;
            end
          end else if (cls == rabd_pkg::CLS_CR) begin
            role   = rabd_pkg::ROLE_LTERM;
            ph_nxt = PH_LLF;
          end else begin
            err = rabd_pkg::ERR_LEN_CHR;
          end
        end
        PH_NEG1: begin
          role = rabd_pkg::ROLE_LCHR;
          if (b == rabd_pkg::CHR_ONE) ph_nxt = PH_NEGCR;
          else                        err    = rabd_pkg::ERR_LEN_CHR;
        end
        PH_NEGCR: begin
          role = rabd_pkg::ROLE_LTERM;
          if (cls == rabd_pkg::CLS_CR) ph_nxt = PH_LLF;
          else                         err    = rabd_pkg::ERR_LEN_CHR;
        end
        PH_LLF: begin
          role = rabd_pkg::ROLE_LTERM;
          if (cls != rabd_pkg::CLS_LF) begin
            err = rabd_pkg::ERR_LEN_CHR;
          end else begin
            len = neg_r ? '0 : acc_r;
            if (arr_r) begin
              if (neg_r || acc_r == '0) begin
                kind   = neg_r ? rabd_pkg::KIND_ARR_NIL : rabd_pkg::KIND_ARR_EMPTY;
                ph_nxt = PH_TYPE;
                fin    = 1'b1;
              end else if (lvl_r >= LvlW'(rabd_pkg::MaxDepth)) begin
                err = rabd_pkg::ERR_DEEP;
              end else begin
                stk_we  = 1'b1;
                stk_wa  = IdxW'(lvl_r);
                stk_wd  = acc_r;
                lvl_nxt = lvl_r + LvlW'(1);
                kind    = rabd_pkg::KIND_ARR_OPEN;
                ph_nxt  = PH_TYPE;
              end
            end else begin
              if (neg_r) begin
                kind   = rabd_pkg::KIND_BULK_NIL;
                ph_nxt = PH_TYPE;
                fin    = 1'b1;
              end else if (acc_r == '0) begin
                rem_nxt = '0;
                ph_nxt  = PH_PCR;
              end else if (acc_r > max_bulk_r) begin
                err = rabd_pkg::ERR_TOO_BIG;
              end else begin
                rem_nxt = acc_r;
                ph_nxt  = PH_PAY;
              end
            end
          end
        end
        PH_PAY: begin
          role    = rabd_pkg::ROLE_PAY;
          rem_nxt = rem_r - 30'd1;
          if (rem_nxt == '0) begin
            last   = 1'b1;
            ph_nxt = PH_PCR;
          end
        end
        PH_PCR: begin
          role = rabd_pkg::ROLE_PTERM;
          if (cls == rabd_pkg::CLS_CR) ph_nxt = PH_PLF;
          else                         err    = rabd_pkg::ERR_TERM;
        end
        PH_PLF: begin
          role = rabd_pkg::ROLE_PTERM;
          if (cls == rabd_pkg::CLS_LF) begin
            kind   = (acc_r == '0) ? rabd_pkg::KIND_BULK_EMPTY : rabd_pkg::KIND_BULK;
            ph_nxt = PH_TYPE;
            fin    = 1'b1;
          end else begin
            err = rabd_pkg::ERR_TERM;
          end
        end
        default: begin
          err = rabd_pkg::ERR_TYPE;
        end
      endcase

      if (err != rabd_pkg::ERR_NONE) begin
        // back to top level with an empty stack
        stk_we   = 1'b0;
        ph_nxt   = PH_TYPE;
        lvl_nxt  = '0;
        acc_nxt  = '0;
        dcnt_nxt = '0;
        neg_nxt  = 1'b0;
        arr_nxt  = 1'b0;
        rem_nxt  = '0;
        ov_nxt       = 1'b1;
        o_role_nxt   = rabd_pkg::ROLE_ERR;
        o_kind_nxt   = rabd_pkg::KIND_NONE;
        o_len_nxt    = '0;
        o_last_nxt   = 1'b0;
        o_closed_nxt = '0;
        o_done_nxt   = 1'b0;
        o_err_nxt    = err;
        o_byte_nxt   = b;
        o_depth_nxt  = '0;
      end else if (fin) begin
        closing_nxt   = 1'b1;
        pk_role_nxt   = role;
        pk_kind_nxt   = kind;
        pk_len_nxt    = len;
        pk_byte_nxt   = b;
        pk_closed_nxt = '0;
      end else begin
        ov_nxt       = 1'b1;
        o_role_nxt   = role;
        o_kind_nxt   = kind;
        o_len_nxt    = len;
        o_last_nxt   = last;
        o_closed_nxt = '0;
        o_done_nxt   = 1'b0;
        o_err_nxt    = rabd_pkg::ERR_NONE;
        o_byte_nxt   = b;
        o_depth_nxt  = 5'(lvl_nxt);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bulk_r <= rabd_pkg::MAX_BULK_RST;
      ph_r       <= PH_TYPE;
      acc_r      <= '0;
      dcnt_r     <= '0;
      neg_r      <= 1'b0;
      arr_r      <= 1'b0;
      rem_r      <= '0;
      lvl_r      <= '0;
      closing_r  <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) max_bulk_r <= cfg_wr_data;
      ph_r      <= ph_nxt;
      acc_r     <= acc_nxt;
      dcnt_r    <= dcnt_nxt;
      neg_r     <= neg_nxt;
      arr_r     <= arr_nxt;
      rem_r     <= rem_nxt;
      lvl_r     <= lvl_nxt;
      closing_r <= closing_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pk_role_r   <= pk_role_nxt;
    pk_kind_r   <= pk_kind_nxt;
    pk_len_r    <= pk_len_nxt;
    pk_byte_r   <= pk_byte_nxt;
    pk_closed_r <= pk_closed_nxt;
    o_role_r    <= o_role_nxt;
    o_kind_r    <= o_kind_nxt;
    o_err_r     <= o_err_nxt;
    o_byte_r    <= o_byte_nxt;
    o_depth_r   <= o_depth_nxt;
    o_closed_r  <= o_closed_nxt;
    o_len_r     <= o_len_nxt;
    o_last_r    <= o_last_nxt;
    o_done_r    <= o_done_nxt;
  end

  // remaining-count stack
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_r[stk_wa] <= stk_wd;
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.byte_role     = o_role_r;
  assign out_ch.byte_echo     = o_byte_r;
  assign out_ch.nesting_depth = o_depth_r;
  assign out_ch.element_kind  = o_kind_r;
  assign out_ch.length_value  = o_len_r;
  assign out_ch.payload_last  = o_last_r;
  assign out_ch.arrays_closed = o_closed_r;
  assign out_ch.message_done  = o_done_r;
  assign out_ch.error_code    = o_err_r;

endmodule

// ----- sim/resp_array_bulk_deframer_core_tb.sv -----
// ----------------------------------------------------------------------------
// resp_array_bulk_deframer_core_tb
// Self-checking bench for the array/bulk request deframer. Request frames,
// broken frames and noise are streamed in byte by byte; a local model of
// the parser predicts every result, which is checked field by field as it
// leaves the block. Both channels idle and stall at random, with a long
// receiver hold-off, and the bulk length limit is changed between phases.
// ----------------------------------------------------------------------------
module resp_array_bulk_deframer_core_tb;

  localparam int          CycleLimit = 400000;
  localparam int          IdxW       = rabd_pkg::IdxW;
  localparam logic [29:0] Mask30     = 30'h3fff_ffff;

  // parser phases of the local model
  typedef enum logic [3:0] {
    PH_TYPE, PH_LFIRST, PH_LDIG, PH_NEG1, PH_NEGCR, PH_LLF, PH_PAY, PH_PCR, PH_PLF
  } phase_t;

  typedef struct packed {
    logic [2:0]  role;
    logic [7:0]  echo;
    logic [4:0]  depth;
    logic [2:0]  kind;
    logic [29:0] len;
    logic        last;
    logic [4:0]  closed;
    logic        done;
    logic [2:0]  err;
  } parse_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [29:0] cfg_wr_data = '0;

  rabd_byte_if in_if();
  rabd_res_if  out_if();

  resp_array_bulk_deframer_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if.sink),
    .out_ch      (out_if.source),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stream state
  logic [7:0] byte_q[$];
  logic [7:0] frame_q[$];
  parse_res_t expected_q[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int failures = 0;
  int bytes_sent = 0;
  int results_checked = 0;
  int errors_seen = 0;
  int msgs_seen = 0;
  int cycles = 0;

  // parser model state
  phase_t      ph = PH_TYPE;
  logic [29:0] len_acc = '0;
  int          ndig = 0;
  bit          neg = 1'b0;
  bit          hdr_arr = 1'b0;
  logic [29:0] pay_left = '0;
  logic [29:0] count_stk[rabd_pkg::MaxDepth];
  int          lvl = 0;
  logic [29:0] max_bulk = rabd_pkg::MAX_BULK_RST;

  // completed element: count down open arrays, cascading upwards
  function automatic void close_element(inout int closed, inout bit done);
    forever begin
      if (lvl == 0 || lvl > rabd_pkg::MaxDepth) begin
        lvl = 0;
        done = 1'b1;
        return;
      end
      count_stk[IdxW'(lvl-1)] = (count_stk[IdxW'(lvl-1)] - 30'd1) & Mask30;
      if (count_stk[IdxW'(lvl-1)] != 0) return;
      lvl--;
      closed++;
    end
  endfunction

  function automatic bit digit_byte(logic [7:0] b);
    return b > rabd_pkg::CHR_DIG_LO && b < rabd_pkg::CHR_DIG_HI;
  endfunction

  function automatic parse_res_t predict_parse(logic [7:0] b);
    parse_res_t r;
    int  closed;
    bit  done;
    logic [31:0] acc32;
    r = '0;
    closed = 0;
    done = 1'b0;
    r.echo = b;
    r.err = rabd_pkg::ERR_NONE;
    case (ph)
      PH_TYPE: begin
        r.role = rabd_pkg::ROLE_TYPE;
        if (b == rabd_pkg::CHR_STAR || b == rabd_pkg::CHR_DOLLAR) begin
          hdr_arr = (b == rabd_pkg::CHR_STAR);
          len_acc = '0;
          ndig = 0;
          neg = 1'b0;
          ph = PH_LFIRST;
        end else r.err = rabd_pkg::ERR_TYPE;
      end
      PH_LFIRST: begin
        r.role = rabd_pkg::ROLE_LCHR;
        if (digit_byte(b)) begin
          len_acc = 30'(b - 8'd48);
          ndig = 1;
          ph = PH_LDIG;
        end else if (b == rabd_pkg::CHR_DASH) begin
          neg = 1'b1;
          ph = PH_NEG1;
        end else r.err = rabd_pkg::ERR_LEN_CHR;
      end
      PH_LDIG: begin
        if (digit_byte(b)) begin
          r.role = rabd_pkg::ROLE_LCHR;
          if (ndig >= rabd_pkg::LenDigits) r.err = rabd_pkg::ERR_LEN_LONG;
          else begin
            acc32 = 32'(len_acc) * 10 + 32'(b - 8'd48);
            len_acc = acc32[29:0];
            ndig++;
          end
        end else if (b == rabd_pkg::CHR_CR) begin
          r.role = rabd_pkg::ROLE_LTERM;
          ph = PH_LLF;
        end else r.err = rabd_pkg::ERR_LEN_CHR;
      end
      PH_NEG1: begin
        r.role = rabd_pkg::ROLE_LCHR;
        if (b == rabd_pkg::CHR_ONE) ph = PH_NEGCR;
        else r.err = rabd_pkg::ERR_LEN_CHR;
      end
      PH_NEGCR: begin
        r.role = rabd_pkg::ROLE_LTERM;
        if (b == rabd_pkg::CHR_CR) ph = PH_LLF;
        else r.err = rabd_pkg::ERR_LEN_CHR;
      end
      PH_LLF: begin
        r.role = rabd_pkg::ROLE_LTERM;
        if (b != rabd_pkg::CHR_LF) r.err = rabd_pkg::ERR_LEN_CHR;
        else begin
          r.len = neg ? 30'd0 : len_acc;
          if (hdr_arr) begin
            if (neg || len_acc == 0) begin
              r.kind = neg ? rabd_pkg::KIND_ARR_NIL : rabd_pkg::KIND_ARR_EMPTY;
              ph = PH_TYPE;
              close_element(closed, done);
            end else if (lvl >= rabd_pkg::MaxDepth) r.err = rabd_pkg::ERR_DEEP;
            else begin
              count_stk[IdxW'(lvl)] = len_acc;
              lvl++;
              r.kind = rabd_pkg::KIND_ARR_OPEN;
              ph = PH_TYPE;
            end
          end else if (neg) begin
            r.kind = rabd_pkg::KIND_BULK_NIL;
            ph = PH_TYPE;
            close_element(closed, done);
          end else if (len_acc == 0) begin
            pay_left = '0;
            ph = PH_PCR;
          end else if (len_acc > max_bulk) r.err = rabd_pkg::ERR_TOO_BIG;
          else begin
            pay_left = len_acc;
            ph = PH_PAY;
          end
        end
      end
      PH_PAY: begin
        r.role = rabd_pkg::ROLE_PAY;
        pay_left = (pay_left - 30'd1) & Mask30;
        if (pay_left == 0) begin
          r.last = 1'b1;
          ph = PH_PCR;
        end
      end
      PH_PCR: begin
        r.role = rabd_pkg::ROLE_PTERM;
        if (b == rabd_pkg::CHR_CR) ph = PH_PLF;
        else r.err = rabd_pkg::ERR_TERM;
      end
      PH_PLF: begin
        r.role = rabd_pkg::ROLE_PTERM;
        if (b == rabd_pkg::CHR_LF) begin
          r.kind = (len_acc == 0) ? rabd_pkg::KIND_BULK_EMPTY : rabd_pkg::KIND_BULK;
          ph = PH_TYPE;
          close_element(closed, done);
        end else r.err = rabd_pkg::ERR_TERM;
      end
      default: begin
        ph = PH_TYPE;
        lvl = 0;
        r.err = rabd_pkg::ERR_TYPE;
      end
    endcase
    if (r.err != rabd_pkg::ERR_NONE) begin
      r.role = rabd_pkg::ROLE_ERR;
      r.kind = rabd_pkg::KIND_NONE;
      r.len = '0;
      r.last = 1'b0;
      closed = 0;
      done = 1'b0;
      ph = PH_TYPE;
      lvl = 0;
      len_acc = '0;
      ndig = 0;
      neg = 1'b0;
      hdr_arr = 1'b0;
      pay_left = '0;
    end
    r.depth = 5'(lvl);
    r.closed = 5'(closed);
    r.done = done;
    return r;
  endfunction

  // sender: one transfer per accepted byte, held until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.data_byte <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_q.push_back(predict_parse(in_if.data_byte));
        bytes_sent++;
      end
      if (in_if.valid && !in_if.ready) begin
        // hold the offered byte
      end else if (byte_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_if.valid <= 1'b1;
        in_if.data_byte <= byte_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, logic [29:0] exp_v, logic [29:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
      failures++;
    end
  endfunction

  // long receiver hold-off, counted in cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 300;
    end
  end

  // receiver: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    parse_res_t e;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: mismatch result expected none actual byte %0d",
                   $time, out_if.byte_echo);
          failures++;
        end else begin
          e = expected_q.pop_front();
          check_field("byte_role", e.role, out_if.byte_role);
          check_field("byte_echo", e.echo, out_if.byte_echo);
          check_field("nesting_depth", e.depth, out_if.nesting_depth);
          check_field("element_kind", e.kind, out_if.element_kind);
          check_field("length_value", e.len, out_if.length_value);
          check_field("payload_last", e.last, out_if.payload_last);
          check_field("arrays_closed", e.closed, out_if.arrays_closed);
          check_field("message_done", e.done, out_if.message_done);
          check_field("error_code", e.err, out_if.error_code);
          results_checked++;
          if (e.err != rabd_pkg::ERR_NONE) errors_seen++;
          if (e.done) msgs_seen++;
        end
      end
      if (hold_left > 0 || hold_req != hold_seen) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // frame building into frame_q
  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endtask

  task automatic push_len(int n, bit zeros);
    if (zeros) push_str("00");
    push_str($sformatf("%0d", n));
    push_str("\r\n");
  endtask

  task automatic push_bulk(int n);
    push_str("$");
    push_len(n, $urandom_range(0, 7) == 0);
    for (int i = 0; i < n; i++) frame_q.push_back(8'($urandom));
    push_str("\r\n");
  endtask

  task automatic gen_element(int depth);
    int n;
    case ($urandom_range(0, 9)) inside
      [0:4]: push_bulk($urandom_range(0, 8));
      5: push_str("$-1\r\n");
      6: push_str($urandom_range(0, 1) ? "*0\r\n" : "*-1\r\n");
      default: begin
        if (depth >= 4) push_bulk($urandom_range(1, 4));
        else begin
          n = $urandom_range(1, 3);
          push_str("*");
          push_len(n, 1'b0);
          for (int i = 0; i < n; i++) gen_element(depth + 1);
        end
      end
    endcase
  endtask

  task automatic flush_frame();
    foreach (frame_q[i]) byte_q.push_back(frame_q[i]);
    frame_q.delete();
  endtask

  // random traffic: mostly whole messages, some broken frames and noise
  task automatic random_traffic(int nbytes);
    int stop_at;
    int cut;
    stop_at = bytes_sent + byte_q.size() + nbytes;
    while (bytes_sent + byte_q.size() < stop_at) begin
      case ($urandom_range(0, 19))
        0: frame_q.push_back(8'($urandom));
        1: begin
          gen_element(0);
          cut = $urandom_range(0, frame_q.size() - 1);
          while (frame_q.size() > cut) void'(frame_q.pop_back());
          frame_q.push_back(8'($urandom));
        end
        2: push_str($urandom_range(0, 1) ? "$999999999\r\n" : "*1234567890");
        3: begin
          for (int i = 0; i < 16; i++) push_str("*1\r\n");
          push_bulk($urandom_range(0, 2));
        end
        default: gen_element(0);
      endcase
      flush_frame();
    end
  endtask

  task automatic write_max_bulk(logic [29:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    max_bulk = v;
  endtask

  task automatic drain();
    while (byte_q.size() > 0 || in_if.valid || expected_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // stimulus sequence
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: type errors, nil/empty forms, extremes, length faults
    frame_q.push_back(8'h00);
    frame_q.push_back(8'hff);
    push_str("+*-1\r\n*0\r\n$-1\r\n$0\r\n\r\n$2\r\n");
    frame_q.push_back(8'h00);
    frame_q.push_back(8'hff);
    push_str("\r\n*1\r\n$1\r\nX\r\n$x$-2$-1x$5\rx$1234567890$1\r\nzq$1\r\nz\rz");
    for (int i = 0; i < 17; i++) push_str("*1\r\n");
    for (int i = 0; i < 16; i++) push_str("*1\r\n");
    push_str("$0\r\n\r\n$999999999\r\n");
    flush_frame();
    drain();

    // sender mostly busy, receiver mostly stalled, one long hold-off
    write_max_bulk(30'd0);
    push_str("$1\r\n$0\r\n\r\n");
    flush_frame();
    send_idle_pct = 12;
    recv_idle_pct = 75;
    hold_req = 1;
    random_traffic(50);
    drain();

    // sender mostly idle, receiver mostly ready
    write_max_bulk(30'd5);
    send_idle_pct = 75;
    recv_idle_pct = 12;
    random_traffic(50);
    drain();

    // no idling either side, widest limits
    write_max_bulk(30'h2000_0000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(50);
    drain();

    write_max_bulk(30'h3fff_ffff);
    random_traffic(50);
    drain();

    $display("Streamed %0d bytes, checked %0d results: %0d errors, %0d messages complete",
             bytes_sent, results_checked, errors_seen, msgs_seen);
    $display("Bulk limit set to 0, 5, 2^29 and all ones; failures: %0d", failures);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
